>>> hw/rtl/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared constants, command codes and the decode result of the
// bounded vector store.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 64;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_PUSH   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_REMOVE = 3'd5,
    CMD_CLEAR  = 3'd6,
    CMD_RESIZE = 3'd7
  } cmd_t;

  typedef struct packed {
    logic             ok;         // command passes bounds and capacity checks
    logic             at_end;     // index equals current length
    logic             no_grow;    // resize target not above current length
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;
  } chk_t;

endpackage

>>> hw/rtl/bvs_check.sv
// ----------------------------------------------------------------------------
// bvs_check
// Bounds and capacity check of one command against the current length.
// ----------------------------------------------------------------------------
module bvs_check (
  input  bvs_pkg::cmd_t                command,
  input  logic [bvs_pkg::CNT_W-1:0]    index,
  input  logic [bvs_pkg::CNT_W-1:0]    length,
  output bvs_pkg::chk_t                chk
);
  import bvs_pkg::*;

  logic in_range;
  logic has_room;
  logic fits;

  assign in_range = (index < length);
  assign has_room = (length < CNT_W'(CAPACITY));
  assign fits     = (index <= CNT_W'(CAPACITY));

  always_comb begin
    chk.at_end    = (index == length);
    chk.no_grow   = (index <= length);
    chk.count_inc = length + CNT_W'(1);
    chk.count_dec = length - CNT_W'(1);
    unique case (command)
      CMD_GET, CMD_SET, CMD_REMOVE: chk.ok = in_range;
      CMD_PUSH:                     chk.ok = has_room;
      CMD_POP:                      chk.ok = (length != '0);
      CMD_INSERT:                   chk.ok = (index <= length) && has_room;
      CMD_CLEAR:                    chk.ok = 1'b1;
      CMD_RESIZE:                   chk.ok = fits;
      default:                      chk.ok = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/bounded_vector_store_unit.sv
// ----------------------------------------------------------------------------
// bounded_vector_store_unit
// Fixed-capacity ordered vector of words held in one synchronous RAM:
// get, set, push, pop, insert, remove, clear and resize.
//
//   channel   ports                              handshake
//   command   start, busy, command/index/value   taken when start && !busy
//   result    done, ok, data, count              done high for one cycle
//   config    cfg_valid, cfg_ready, cfg_data     written when valid && ready
//
// Get and pop read the RAM, then report; set, push, clear, resize down, insert
// at the end and every failed command finish from the idle state. Insert
// below the end shifts words up, remove shifts them down and resize growth
// fills, one word per cycle through the single write port. The result
// register shows the item the cycle after the command finishes; a new item
// may start in that cycle.
// Reset (rst, synchronous) empties the vector and zeroes empty_value; RAM
// contents are not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
module bounded_vector_store_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      command,
  input  logic [bvs_pkg::CNT_W-1:0]       index,
  input  logic [bvs_pkg::WORD_BITS-1:0]   value,
  output logic                            done,
  output logic                            ok,
  output logic [bvs_pkg::WORD_BITS-1:0]   data,
  output logic [bvs_pkg::CNT_W-1:0]       count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bvs_pkg::WORD_BITS-1:0]   cfg_data
);
  import bvs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_UP    = 6'b000100,
    S_PLACE = 6'b001000,
    S_DOWN  = 6'b010000,
    S_FILL  = 6'b100000
  } state_t;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;

  state_t               state, state_next;
  logic [CNT_W-1:0]     length, length_next;
  logic [CNT_W-1:0]     length_dec;
  logic [ADDR_W-1:0]    ptr, ptr_next;
  cmd_t                 cmd_q, cmd_next;
  logic [CNT_W-1:0]     idx_q, idx_next;
  logic [WORD_BITS-1:0] val_q, val_next;
  logic [WORD_BITS-1:0] hold, hold_next;
  logic [WORD_BITS-1:0] empty_value;
  logic                 done_next;
  logic                 ok_next;
  logic [WORD_BITS-1:0] data_next;
  logic [CNT_W-1:0]     count_next;
  cmd_t                 cmd_in;
  chk_t                 chk;

  assign cmd_in     = cmd_t'(command);
  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign length_dec = length - CNT_W'(1);

  bvs_check u_check (
    .command (cmd_in),
    .index   (index),
    .length  (length),
    .chk     (chk)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next  = state;
    length_next = length;
    ptr_next    = ptr;
    cmd_next    = cmd_q;
    idx_next    = idx_q;
    val_next    = val_q;
    hold_next   = hold;
    done_next   = 1'b0;
    ok_next     = ok;
    data_next   = data;
    count_next  = count;
    mem_we      = 1'b0;
    mem_waddr   = ptr;
    mem_wdata   = rd_data;
    mem_re      = 1'b0;
    mem_raddr   = ptr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next  = cmd_in;
          idx_next  = index;
          val_next  = value;
          data_next = '0;
          if (!chk.ok) begin
            done_next  = 1'b1;
            ok_next    = 1'b0;
            count_next = length;
          end else begin
            unique case (cmd_in)
              CMD_GET: begin
                mem_re     = 1'b1;
                mem_raddr  = index[ADDR_W-1:0];
                state_next = S_READ;
              end
              CMD_SET: begin
                mem_we     = 1'b1;
                mem_waddr  = index[ADDR_W-1:0];
                mem_wdata  = value;
                done_next  = 1'b1;
                ok_next    = 1'b1;
                count_next = length;
              end
              CMD_PUSH: begin
                mem_we      = 1'b1;
                mem_waddr   = length[ADDR_W-1:0];
                mem_wdata   = value;
                length_next = chk.count_inc;
                done_next   = 1'b1;
                ok_next     = 1'b1;
                count_next  = chk.count_inc;
              end
              CMD_POP: begin
                mem_re      = 1'b1;
                mem_raddr   = chk.count_dec[ADDR_W-1:0];
                length_next = chk.count_dec;
                state_next  = S_READ;
              end
              CMD_INSERT: begin
                if (chk.at_end) begin
                  mem_we      = 1'b1;
                  mem_waddr   = index[ADDR_W-1:0];
                  mem_wdata   = value;
                  length_next = chk.count_inc;
                  done_next   = 1'b1;
                  ok_next     = 1'b1;
                  count_next  = chk.count_inc;
                end else begin
                  // shift from the top down, read runs one slot ahead of write
                  mem_re     = 1'b1;
                  mem_raddr  = chk.count_dec[ADDR_W-1:0];
                  ptr_next   = chk.count_dec[ADDR_W-1:0];
                  state_next = S_UP;
                end
              end
              CMD_REMOVE: begin
                mem_re     = 1'b1;
                mem_raddr  = index[ADDR_W-1:0];
                state_next = S_READ;
              end
              CMD_CLEAR: begin
                length_next = '0;
                done_next   = 1'b1;
                ok_next     = 1'b1;
                count_next  = '0;
              end
              CMD_RESIZE: begin
                if (chk.no_grow) begin
                  length_next = index;
                  done_next   = 1'b1;
                  ok_next     = 1'b1;
                  count_next  = index;
                end else begin
                  ptr_next   = length[ADDR_W-1:0];
                  state_next = S_FILL;
                end
              end
              default: begin
                done_next  = 1'b1;
                ok_next    = 1'b0;
                count_next = length;
              end
            endcase
          end
        end
      end

      S_READ: begin
        if (cmd_q == CMD_REMOVE) begin
          hold_next = rd_data;
          if (idx_q == length_dec) begin
            length_next = length_dec;
            state_next  = S_IDLE;
            done_next   = 1'b1;
            ok_next     = 1'b1;
            data_next   = rd_data;
            count_next  = length_dec;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = idx_q[ADDR_W-1:0] + ADDR_W'(1);
            ptr_next   = idx_q[ADDR_W-1:0] + ADDR_W'(1);
            state_next = S_DOWN;
          end
        end else begin
          // get and pop
          state_next = S_IDLE;
          done_next  = 1'b1;
          ok_next    = 1'b1;
          data_next  = rd_data;
          count_next = length;
        end
      end

      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr + ADDR_W'(1);
        mem_wdata = rd_data;
        if (ptr == idx_q[ADDR_W-1:0]) begin
          state_next = S_PLACE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr - ADDR_W'(1);
          ptr_next  = ptr - ADDR_W'(1);
        end
      end

      S_PLACE: begin
        mem_we      = 1'b1;
        mem_waddr   = idx_q[ADDR_W-1:0];
        mem_wdata   = val_q;
        length_next = length + CNT_W'(1);
        state_next  = S_IDLE;
        done_next   = 1'b1;
        ok_next     = 1'b1;
        data_next   = '0;
        count_next  = length + CNT_W'(1);
      end

      S_DOWN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr - ADDR_W'(1);
        mem_wdata = rd_data;
        if (CNT_W'(ptr) == length_dec) begin
          length_next = length_dec;
          state_next  = S_IDLE;
          done_next   = 1'b1;
          ok_next     = 1'b1;
          data_next   = hold;
          count_next  = length_dec;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr + ADDR_W'(1);
          ptr_next  = ptr + ADDR_W'(1);
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = empty_value;
        if (CNT_W'(ptr) + CNT_W'(1) == idx_q) begin
          length_next = idx_q;
          state_next  = S_IDLE;
          done_next   = 1'b1;
          ok_next     = 1'b1;
          data_next   = '0;
          count_next  = idx_q;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      length      <= '0;
      done        <= 1'b0;
      empty_value <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
      done   <= done_next;
      if (cfg_valid && cfg_ready) begin
        empty_value <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    cmd_q <= cmd_next;
    idx_q <= idx_next;
    val_q <= val_next;
    hold  <= hold_next;
    ok    <= ok_next;
    data  <= data_next;
    count <= count_next;
  end

endmodule

>>> test/bounded_vector_store_unit_tb.sv
// ----------------------------------------------------------------------------
// bounded_vector_store_unit_tb
// Self-checking bench for the bounded vector store. A scoreboard class keeps
// its own copy of the element store, the length and the fill word. It works
// out the expected result of every accepted command and compares each
// result strobe with the oldest expected result. A directed pass covers
// bounds, capacity and resize corners. Random passes under three sender
// idle rates follow, and the fill word is rewritten between passes.
// ----------------------------------------------------------------------------
module bounded_vector_store_unit_tb;
  import bvs_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic                 ok;
    logic [WORD_BITS-1:0] data;
    logic [CNT_W-1:0]     count;
  } vec_result_t;

  class vector_scoreboard;
    logic [WORD_BITS-1:0] slots [CAPACITY];
    int unsigned          length;
    logic [WORD_BITS-1:0] fill_word;
    vec_result_t          due_q[$];
    int                   errors;

    function new();
      length    = 0;
      fill_word = '0;
      errors    = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // apply one accepted command to the shadow vector and queue its result
    function void note_input(cmd_t c, int unsigned idx, logic [WORD_BITS-1:0] v);
      vec_result_t r;
      int unsigned i;
      r.ok   = 1'b0;
      r.data = '0;
      case (c)
        CMD_GET: begin
          if (idx < length) begin
            r.data = slots[idx];
            r.ok   = 1'b1;
          end
        end
        CMD_SET: begin
          if (idx < length) begin
            slots[idx] = v;
            r.ok       = 1'b1;
          end
        end
        CMD_PUSH: begin
          if (length < CAPACITY) begin
            slots[length] = v;
            length++;
            r.ok = 1'b1;
          end
        end
        CMD_POP: begin
          if (length > 0) begin
            length--;
            r.data = slots[length];
            r.ok   = 1'b1;
          end
        end
        CMD_INSERT: begin
          if (idx <= length && length < CAPACITY) begin
            for (i = length; i > idx; i--) slots[i] = slots[i-1];
            slots[idx] = v;
            length++;
            r.ok = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (idx < length) begin
            r.data = slots[idx];
            for (i = idx; i + 1 < length; i++) slots[i] = slots[i+1];
            length--;
            r.ok = 1'b1;
          end
        end
        CMD_CLEAR: begin
          length = 0;
          r.ok   = 1'b1;
        end
        default: begin
          // resize: growth fills new slots, shrink only lowers the length
          if (idx <= CAPACITY) begin
            for (i = length; i < idx; i++) slots[i] = fill_word;
            length = idx;
            r.ok   = 1'b1;
          end
        end
      endcase
      r.count = CNT_W'(length);
      due_q.push_back(r);
    endfunction

    function void check_result(logic got_ok, logic [WORD_BITS-1:0] got_data,
                               logic [CNT_W-1:0] got_count);
      vec_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        $error("result strobe with no item outstanding");
        return;
      end
      want = due_q.pop_front();
      if (got_ok !== want.ok) begin
        errors++;
        $error("ok: expected %0d, actual %0d", want.ok, got_ok);
      end
      if (got_data !== want.data) begin
        errors++;
        $error("data: expected %h, actual %h", want.data, got_data);
      end
      if (got_count !== want.count) begin
        errors++;
        $error("count: expected %0d, actual %0d", want.count, got_count);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  cmd_t                 command   = CMD_GET;
  logic [CNT_W-1:0]     index     = '0;
  logic [WORD_BITS-1:0] value     = '0;
  logic                 done;
  logic                 ok;
  logic [WORD_BITS-1:0] data;
  logic [CNT_W-1:0]     count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WORD_BITS-1:0] cfg_data  = '0;

  vector_scoreboard sb = new();
  int               sender_idle_pct = 0;
  int               quiet_cycles = 0;

  bounded_vector_store_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .index     (index),
    .value     (value),
    .done      (done),
    .ok        (ok),
    .data      (data),
    .count     (count),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(ok, data, count);
  end

  // ends the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic hold_off();
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // returns at the edge that takes the item; start stays high for the next one
  task automatic send_item(input cmd_t c, input logic [CNT_W-1:0] idx,
                           input logic [WORD_BITS-1:0] v);
    hold_off();
    start   <= 1'b1;
    command <= c;
    index   <= idx;
    value   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(c, idx, v);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_empty_value(input logic [WORD_BITS-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    sb.fill_word = v;
  endtask

  task automatic run_directed();
    send_item(CMD_POP,    9'd0,   '0);                     // pop on empty
    send_item(CMD_GET,    9'd0,   '0);                     // get on empty
    send_item(CMD_REMOVE, 9'd0,   '0);
    send_item(CMD_PUSH,   9'd0,   '0);
    send_item(CMD_PUSH,   9'd0,   '1);
    send_item(CMD_GET,    9'd1,   '0);
    send_item(CMD_SET,    9'd0,   64'hA5A5_5A5A_0F0F_F0F0);
    send_item(CMD_SET,    9'd2,   64'h1234_5678_9ABC_DEF0); // set past end
    send_item(CMD_INSERT, 9'd0,   64'h0000_0000_0000_0001);
    send_item(CMD_INSERT, 9'd3,   64'h8000_0000_0000_0000); // insert at end appends
    send_item(CMD_INSERT, 9'd5,   64'h5555_5555_5555_5555); // insert past end
    send_item(CMD_REMOVE, 9'd1,   '0);
    send_item(CMD_REMOVE, 9'd511, '0);
    send_item(CMD_RESIZE, 9'd256, '0);                     // grow to capacity
    send_item(CMD_PUSH,   9'd0,   64'hDEAD_BEEF_CAFE_F00D); // push when full
    send_item(CMD_INSERT, 9'd0,   64'hDEAD_BEEF_CAFE_F00D); // insert when full
    send_item(CMD_GET,    9'd255, '0);
    send_item(CMD_REMOVE, 9'd0,   '0);                     // longest shift left
    send_item(CMD_INSERT, 9'd0,   64'hFEDC_BA98_7654_3210); // longest shift right
    send_item(CMD_RESIZE, 9'd257, '0);                     // resize above capacity
    send_item(CMD_RESIZE, 9'd511, '0);
    send_item(CMD_RESIZE, 9'd2,   '0);                     // shrink
    send_item(CMD_GET,    9'd1,   '0);
    send_item(CMD_CLEAR,  9'd0,   '0);
    send_item(CMD_RESIZE, 9'd0,   '0);
  endtask

  function automatic cmd_t pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 18) return CMD_GET;
    if (r < 30) return CMD_SET;
    if (r < 48) return CMD_PUSH;
    if (r < 60) return CMD_POP;
    if (r < 75) return CMD_INSERT;
    if (r < 87) return CMD_REMOVE;
    if (r < 90) return CMD_CLEAR;
    return CMD_RESIZE;
  endfunction

  // mostly in-range positions, with the end position and wild ones mixed in
  function automatic logic [CNT_W-1:0] pick_index(cmd_t c, int unsigned len);
    int unsigned r;
    r = $urandom_range(99);
    if (c == CMD_RESIZE) begin
      if (r < 45) return CNT_W'($urandom_range(40));
      if (r < 60) return CNT_W'(len + $urandom_range(4));
      if (r < 70) return CNT_W'(CAPACITY);
      if (r < 82) return CNT_W'($urandom_range(CAPACITY));
      return CNT_W'($urandom_range(511, CAPACITY + 1));
    end
    if (r < 70 && len > 0) return CNT_W'($urandom_range(len - 1));
    if (r < 82) return CNT_W'(len);
    return CNT_W'($urandom_range(511));
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic run_random(input int n);
    cmd_t c;
    for (int k = 0; k < n; k++) begin
      c = pick_command();
      send_item(c, pick_index(c, sb.length), pick_word());
      if ($urandom_range(63) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_empty_value('1);
    run_directed();
    write_empty_value('0);
    sender_idle_pct = 21;
    run_random(320);
    write_empty_value({$urandom, $urandom});
    sender_idle_pct = 87;
    run_random(320);
    write_empty_value(64'h8000_0000_0000_0001);
    sender_idle_pct = 0;
    run_random(310);
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> bounded_vector_store_unit.f
hw/rtl/bvs_pkg.sv
hw/rtl/bvs_check.sv
hw/rtl/bounded_vector_store_unit.sv
test/bounded_vector_store_unit_tb.sv
